/* hdl/hsv_pkg.sv */
// shared constants and types for the hsv to rgb converter
`default_nettype none

package hsv_pkg;

    // hue field and derived widths
    localparam int HUE_BITS = 9;
    localparam int REM_BITS = 7;   // hue mod 120
    localparam int K_BITS   = 6;   // 60 minus distance, 0..60
    localparam int FT_BITS  = 7;   // small quotient of the second divide, 0..89

    // degrees in one sector
    localparam int SECTOR_DEG = 60;

    // 60-degree sector of the hue
    typedef logic [2:0] sector_t;

    localparam sector_t SEC_RY = 3'd0;  // red to yellow:    C, X, 0
    localparam sector_t SEC_YG = 3'd1;  // yellow to green:  X, C, 0
    localparam sector_t SEC_GC = 3'd2;  // green to cyan:    0, C, X
    localparam sector_t SEC_CB = 3'd3;  // cyan to blue:     0, X, C
    localparam sector_t SEC_BM = 3'd4;  // blue to magenta:  X, 0, C
    localparam sector_t SEC_MR = 3'd5;  // magenta to red:   C, 0, X

endpackage

`default_nettype wire

/* hdl/hsv_front.sv */
// first stage: hue sector decode, weight for the intermediate and s*v product
`default_nettype none

module hsv_front #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hsv_pkg::HUE_BITS-1:0]   hue,
    input  logic [CHANNEL_BITS-1:0]        saturation,
    input  logic [CHANNEL_BITS-1:0]        brightness,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2*CHANNEL_BITS-1:0]      prod,
    output hsv_pkg::sector_t               sector,
    output logic [hsv_pkg::K_BITS-1:0]     weight,
    output logic [CHANNEL_BITS-1:0]        val
);
    import hsv_pkg::*;

    localparam int N = CHANNEL_BITS;

    logic                 valid_reg;
    logic [2*N-1:0]       prod_reg;
    logic [2*N-1:0]       prod_next;
    sector_t              sector_reg;
    sector_t              sector_next;
    logic [K_BITS-1:0]    weight_reg;
    logic [K_BITS-1:0]    weight_next;
    logic [N-1:0]         val_reg;
    logic [HUE_BITS-1:0]  rem_wide;
    logic [REM_BITS-1:0]  rem;
    logic [REM_BITS-1:0]  hue_dist;
    logic [REM_BITS-1:0]  weight_wide;

    assign in_ready = !valid_reg || out_ready;

    // sector of the hue, anything from 300 up lands in the last one
    always_comb begin
        priority if (hue >= 9'd300) begin
            sector_next = SEC_MR;
        end else if (hue >= 9'd240) begin
            sector_next = SEC_BM;
        end else if (hue >= 9'd180) begin
            sector_next = SEC_CB;
        end else if (hue >= 9'd120) begin
            sector_next = SEC_GC;
        end else if (hue >= 9'd60) begin
            sector_next = SEC_YG;
        end else begin
            sector_next = SEC_RY;
        end
    end

    // hue mod 120 by picking the multiple to take off
    always_comb begin
        priority if (hue >= 9'd480) begin
            rem_wide = hue - 9'd480;
        end else if (hue >= 9'd360) begin
            rem_wide = hue - 9'd360;
        end else if (hue >= 9'd240) begin
            rem_wide = hue - 9'd240;
        end else if (hue >= 9'd120) begin
            rem_wide = hue - 9'd120;
        end else begin
            rem_wide = hue;
        end
    end

    // weight = 60 - |rem - 60|
    always_comb begin
        rem = rem_wide[REM_BITS-1:0];
        if (rem >= REM_BITS'(SECTOR_DEG)) begin
            hue_dist = rem - REM_BITS'(SECTOR_DEG);
        end else begin
            hue_dist = REM_BITS'(SECTOR_DEG) - rem;
        end
        weight_wide = REM_BITS'(SECTOR_DEG) - hue_dist;
        weight_next = weight_wide[K_BITS-1:0];
        prod_next   = (2*N)'(saturation) * (2*N)'(brightness);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg   <= prod_next;
            sector_reg <= sector_next;
            weight_reg <= weight_next;
            val_reg    <= brightness;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;
    assign sector    = sector_reg;
    assign weight    = weight_reg;
    assign val       = val_reg;

endmodule

`default_nettype wire

/* hdl/hsv_div_full.sv */
// two-stage divide by full scale (2^n - 1): shift estimate, then remainder correction
`default_nettype none

module hsv_div_full #(
    parameter int CHANNEL_BITS = 8,
    parameter int NUM_BITS     = 16,
    parameter int QUOT_BITS    = 8,
    parameter int SIDE_BITS    = 17
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUM_BITS-1:0]     num,
    input  logic [SIDE_BITS-1:0]    side_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [QUOT_BITS-1:0]    quot,
    output logic [CHANNEL_BITS-1:0] rem,
    output logic [SIDE_BITS-1:0]    side_out
);

    localparam int N       = CHANNEL_BITS;
    localparam int QE_BITS = NUM_BITS - N + 1;
    localparam int RE_BITS = N + 2;
    localparam logic [RE_BITS-1:0] FULL_R = RE_BITS'((1 << N) - 1);

    logic                  va_reg;
    logic                  vb_reg;
    logic                  rdy_a;
    logic                  rdy_b;
    logic [NUM_BITS:0]     sum_est;
    logic [NUM_BITS+1:0]   r_wide;
    logic [QE_BITS-1:0]    qe_next;
    logic [QE_BITS-1:0]    qe_reg;
    logic [RE_BITS-1:0]    re_next;
    logic [RE_BITS-1:0]    re_reg;
    logic [SIDE_BITS-1:0]  side_a_reg;
    logic [QE_BITS-1:0]    q_fix;
    logic [RE_BITS-1:0]    r_fix;
    logic [QUOT_BITS-1:0]  q_reg;
    logic [N-1:0]          r_reg;
    logic [SIDE_BITS-1:0]  side_b_reg;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // estimate x/(2^n-1) as (x + x>>n)>>n, low by at most one
    always_comb begin
        sum_est = {1'b0, num} + (NUM_BITS+1)'(num >> N);
        qe_next = sum_est[NUM_BITS:N];
        r_wide  = (NUM_BITS+2)'(num) + (NUM_BITS+2)'(qe_next)
                - ((NUM_BITS+2)'(qe_next) << N);
        re_next = r_wide[RE_BITS-1:0];
    end

    // pull the remainder back under full scale
    always_comb begin
        q_fix = qe_reg;
        r_fix = re_reg;
        for (int i = 0; i < 2; i++) begin
            if (r_fix >= FULL_R) begin
                r_fix = r_fix - FULL_R;
                q_fix = q_fix + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            qe_reg     <= qe_next;
            re_reg     <= re_next;
            side_a_reg <= side_in;
        end
        if (rdy_b && va_reg) begin
            q_reg      <= q_fix[QUOT_BITS-1:0];
            r_reg      <= r_fix[N-1:0];
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign quot      = q_reg;
    assign rem       = r_reg;
    assign side_out  = side_b_reg;

endmodule

`default_nettype wire

/* hdl/hsv_div60.sv */
// two-stage divide by 60 for the intermediate: reciprocal multiply, then one correction
`default_nettype none

module hsv_div60 #(
    parameter int CHANNEL_BITS = 8,
    parameter int SIDE_BITS    = 19
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [CHANNEL_BITS+5:0]       coarse,
    input  logic [hsv_pkg::FT_BITS-1:0]   fine,
    input  logic [SIDE_BITS-1:0]          side_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS-1:0]       mid,
    output logic [SIDE_BITS-1:0]          side_out
);
    import hsv_pkg::*;

    localparam int N      = CHANNEL_BITS;
    localparam int W_BITS = N + 6;
    localparam logic [N:0] RECIP = (N+1)'((1 << W_BITS) / SECTOR_DEG);

    logic                  va_reg;
    logic                  vb_reg;
    logic                  rdy_a;
    logic                  rdy_b;
    logic [W_BITS:0]       w_sum;
    logic [W_BITS-1:0]     w_next;
    logic [2*N+6:0]        w_prod;
    logic [W_BITS-1:0]     w_reg;
    logic [N:0]            qe_reg;
    logic [SIDE_BITS-1:0]  side_a_reg;
    logic [W_BITS:0]       q60;
    logic [W_BITS-1:0]     r60;
    logic [N:0]            q_fix;
    logic [N-1:0]          mid_reg;
    logic [SIDE_BITS-1:0]  side_b_reg;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // full quotient by full scale, then times the reciprocal of 60
    always_comb begin
        w_sum  = (W_BITS+1)'(coarse) + (W_BITS+1)'(fine);
        w_next = w_sum[W_BITS-1:0];
        w_prod = (2*N+7)'(w_next) * (2*N+7)'(RECIP);
    end

    // estimate is low by at most one
    always_comb begin
        q60   = (W_BITS+1)'(qe_reg) * (W_BITS+1)'(SECTOR_DEG);
        r60   = w_reg - q60[W_BITS-1:0];
        q_fix = qe_reg;
        if (r60 >= W_BITS'(SECTOR_DEG)) begin
            q_fix = qe_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            w_reg      <= w_next;
            qe_reg     <= w_prod[2*N+6:W_BITS];
            side_a_reg <= side_in;
        end
        if (rdy_b && va_reg) begin
            mid_reg    <= q_fix[N-1:0];
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign mid       = mid_reg;
    assign side_out  = side_b_reg;

endmodule

`default_nettype wire

/* hdl/hsv_mix.sv */
// output stage: place chroma and intermediate by sector, add the offset
`default_nettype none

module hsv_mix #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  hsv_pkg::sector_t        sector,
    input  logic [CHANNEL_BITS-1:0] val,
    input  logic [CHANNEL_BITS-1:0] chroma,
    input  logic [CHANNEL_BITS-1:0] mid,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue
);
    import hsv_pkg::*;

    localparam int N = CHANNEL_BITS;

    logic         valid_reg;
    logic [N-1:0] base;
    logic [N-1:0] r_raw;
    logic [N-1:0] g_raw;
    logic [N-1:0] b_raw;
    logic [N-1:0] red_reg;
    logic [N-1:0] green_reg;
    logic [N-1:0] blue_reg;

    assign in_ready = !valid_reg || out_ready;
    assign base     = val - chroma;

    // channel placement per sector
    always_comb begin
        unique case (sector)
            SEC_RY: begin
                r_raw = chroma; g_raw = mid;    b_raw = '0;
            end
            SEC_YG: begin
                r_raw = mid;    g_raw = chroma; b_raw = '0;
            end
            SEC_GC: begin
                r_raw = '0;     g_raw = chroma; b_raw = mid;
            end
            SEC_CB: begin
                r_raw = '0;     g_raw = mid;    b_raw = chroma;
            end
            SEC_BM: begin
                r_raw = mid;    g_raw = '0;     b_raw = chroma;
            end
            SEC_MR: begin
                r_raw = chroma; g_raw = '0;     b_raw = mid;
            end
            default: begin
                r_raw = '0;     g_raw = '0;     b_raw = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg   <= r_raw + base;
            green_reg <= g_raw + base;
            blue_reg  <= b_raw + base;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

/* hdl/hsv_to_rgb_converter.sv */
// HSV to RGB colour converter: one colour per beat, nine pipeline stages.
//
// Input stream (s_*): one beat per colour, tdata holds hue (9 bits, whole degrees),
// then saturation and value (CHANNEL_BITS each, all ones means 1.0), zero padded
// to whole bytes. Output stream (m_*): one beat per colour with red, green and
// blue, CHANNEL_BITS each, zero padded to whole bytes.
//
// Throughput is one colour per clock while m_tready is high. From input beat to
// output beat: one stage for sector decode and the s*v product, two for the
// divide by full scale of the chroma, one for the weight multiplies, two for the
// divide by full scale of the intermediate, two for the divide by 60 and one
// for the channel mix, which is also the output register.
//
// Every stage carries its own valid bit and moves on when the next stage is
// empty or moving, so bubbles close up. When the receiver holds m_tready low,
// the pipeline keeps filling until all nine stages hold a colour, then drops
// s_tready; nothing is lost or repeated. Reset empties all stages; the output
// is invalid in the cycle after reset.
`default_nettype none

module hsv_to_rgb_converter #(
    parameter  int CHANNEL_BITS = 8,
    localparam int S_TDATA_BITS = ((hsv_pkg::HUE_BITS + 2*CHANNEL_BITS + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((3*CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // hue, saturation, brightness
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata    // red, green, blue
);
    import hsv_pkg::*;

    localparam int N          = CHANNEL_BITS;
    localparam int T_BITS     = N + 7;
    localparam int QCK_BITS   = N + 6;
    localparam int SIDE1_BITS = 3 + K_BITS + N;
    localparam int SIDE2_BITS = 3 + 2*N + QCK_BITS;
    localparam int SIDE3_BITS = 3 + 2*N;
    localparam logic [N-1:0]      HALF_UP  = N'(1 << (N - 1));
    localparam logic [T_BITS-1:0] HALF_DEN = T_BITS'(30 * ((1 << N) - 1));

    // input fields
    logic [HUE_BITS-1:0] in_hue;
    logic [N-1:0]        in_sat;
    logic [N-1:0]        in_val;

    // front stage
    logic                f_valid;
    logic                f_ready;
    logic [2*N-1:0]      f_prod;
    sector_t             f_sector;
    logic [K_BITS-1:0]   f_weight;
    logic [N-1:0]        f_val;

    // chroma divide
    logic                d1_valid;
    logic                d1_ready;
    logic [N-1:0]        d1_quot;
    logic [N-1:0]        d1_rem;
    logic [SIDE1_BITS-1:0] d1_side_in;
    logic [SIDE1_BITS-1:0] d1_side_out;
    sector_t             d1_sector;
    logic [K_BITS-1:0]   d1_weight;
    logic [N-1:0]        d1_val;

    // weight multiply stage
    logic                wm_valid_reg;
    logic                wm_ready;
    logic [T_BITS-1:0]   t_reg;
    logic [T_BITS-1:0]   t_next;
    logic [QCK_BITS-1:0] qck_reg;
    logic [QCK_BITS-1:0] qck_next;
    logic [N-1:0]        chroma_reg;
    logic [N:0]          chroma_wide;
    sector_t             wm_sector_reg;
    logic [N-1:0]        wm_val_reg;

    // intermediate divide by full scale
    logic                d2_valid;
    logic                d2_ready;
    logic [FT_BITS-1:0]  d2_quot;
    logic [SIDE2_BITS-1:0] d2_side_in;
    logic [SIDE2_BITS-1:0] d2_side_out;
    logic [QCK_BITS-1:0] d2_qck;
    logic [SIDE3_BITS-1:0] d2_keep;

    // divide by 60
    logic                d3_valid;
    logic                d3_ready;
    logic [N-1:0]        d3_mid;
    logic [SIDE3_BITS-1:0] d3_side_out;
    sector_t             d3_sector;
    logic [N-1:0]        d3_val;
    logic [N-1:0]        d3_chroma;

    // output channels
    logic [N-1:0]        out_red;
    logic [N-1:0]        out_green;
    logic [N-1:0]        out_blue;

    assign in_hue = s_tdata[HUE_BITS-1:0];
    assign in_sat = s_tdata[HUE_BITS+N-1:HUE_BITS];
    assign in_val = s_tdata[HUE_BITS+2*N-1:HUE_BITS+N];

    hsv_front #(
        .CHANNEL_BITS (N)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (in_hue),
        .saturation (in_sat),
        .brightness (in_val),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .prod       (f_prod),
        .sector     (f_sector),
        .weight     (f_weight),
        .val        (f_val)
    );

    // s*v by full scale gives floor and remainder of the chroma
    assign d1_side_in = {f_sector, f_weight, f_val};

    hsv_div_full #(
        .CHANNEL_BITS (N),
        .NUM_BITS     (2*N),
        .QUOT_BITS    (N),
        .SIDE_BITS    (SIDE1_BITS)
    ) u_div_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .num       (f_prod),
        .side_in   (d1_side_in),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quot      (d1_quot),
        .rem       (d1_rem),
        .side_out  (d1_side_out)
    );

    assign {d1_sector, d1_weight, d1_val} = d1_side_out;

    // rounded chroma, and the intermediate split as floor*weight plus remainder part
    assign d1_ready = !wm_valid_reg || wm_ready;

    always_comb begin
        chroma_wide = (N+1)'(d1_quot) + (N+1)'(d1_rem >= HALF_UP);
        t_next      = T_BITS'(d1_rem) * T_BITS'(d1_weight) + HALF_DEN;
        qck_next    = QCK_BITS'(d1_quot) * QCK_BITS'(d1_weight);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm_valid_reg <= 1'b0;
        end else if (d1_ready) begin
            wm_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d1_ready && d1_valid) begin
            t_reg         <= t_next;
            qck_reg       <= qck_next;
            chroma_reg    <= chroma_wide[N-1:0];
            wm_sector_reg <= d1_sector;
            wm_val_reg    <= d1_val;
        end
    end

    // remainder part of the intermediate by full scale
    assign d2_side_in = {wm_sector_reg, wm_val_reg, chroma_reg, qck_reg};

    hsv_div_full #(
        .CHANNEL_BITS (N),
        .NUM_BITS     (T_BITS),
        .QUOT_BITS    (FT_BITS),
        .SIDE_BITS    (SIDE2_BITS)
    ) u_div_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (wm_valid_reg),
        .in_ready  (wm_ready),
        .num       (t_reg),
        .side_in   (d2_side_in),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .quot      (d2_quot),
        .rem       (),
        .side_out  (d2_side_out)
    );

    assign {d2_keep, d2_qck} = d2_side_out;

    hsv_div60 #(
        .CHANNEL_BITS (N),
        .SIDE_BITS    (SIDE3_BITS)
    ) u_div60 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .coarse    (d2_qck),
        .fine      (d2_quot),
        .side_in   (d2_keep),
        .out_valid (d3_valid),
        .out_ready (d3_ready),
        .mid       (d3_mid),
        .side_out  (d3_side_out)
    );

    assign {d3_sector, d3_val, d3_chroma} = d3_side_out;

    hsv_mix #(
        .CHANNEL_BITS (N)
    ) u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d3_valid),
        .in_ready  (d3_ready),
        .sector    (d3_sector),
        .val       (d3_val),
        .chroma    (d3_chroma),
        .mid       (d3_mid),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (out_red),
        .green     (out_green),
        .blue      (out_blue)
    );

    assign m_tdata = M_TDATA_BITS'({out_blue, out_green, out_red});

endmodule

`default_nettype wire
